// ----- hdl/emps_pkg.sv -----
// ============================================================================
// emps_pkg: shared types and constants of the population step block
// Field widths, configuration map, multiplier schedule codes and the
// command and status bundles between controller and datapath.
// ============================================================================
package emps_pkg;

    localparam int POP_W   = 40;   // population, unsigned Q24.16
    localparam int RATE_W  = 32;   // rates and step values, unsigned Q8.24
    localparam int NOISE_W = 16;   // noise sample, signed Q4.12

    // configuration port
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;
    localparam int REG_LSB   = 3;  // registers sit on 8-byte boundaries

    localparam logic [REG_IDX_W-1:0] REG_BIRTH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEATH    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SQRT_DT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_START    = 3'd6;

    // square root iterations: one result bit per cycle
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic [RATE_W-1:0] birth_rate;
        logic [RATE_W-1:0] death_rate;
        logic [RATE_W-1:0] feedback_gain;
        logic [POP_W-1:0]  setpoint;
        logic [RATE_W-1:0] step_size;
        logic [RATE_W-1:0] sqrt_step;
        logic [POP_W-1:0]  start_value;
    } cfg_t;

    // partial products issued to the shared 32x32 multiplier
    typedef enum logic [3:0] {
        MUL_FB_LO  = 4'd0,
        MUL_FB_HI  = 4'd1,
        MUL_DR1_LO = 4'd2,
        MUL_DR1_HI = 4'd3,
        MUL_DR2_LO = 4'd4,
        MUL_DR2_HI = 4'd5,
        MUL_VAR_LL = 4'd6,
        MUL_VAR_HL = 4'd7,
        MUL_VAR_LH = 4'd8,
        MUL_VAR_HH = 4'd9,
        MUL_DF1    = 4'd10,
        MUL_DF2_LO = 4'd11,
        MUL_DF2_HI = 4'd12
    } mul_op_t;

    typedef struct packed {
        logic    accept;      // capture the noise word
        logic    load_start;  // restart: load start value, clear extinct
        logic    diff;        // distance to setpoint
        logic    beff;        // effective birth rate
        logic    rate;        // net rate and variance rate
        logic    mul_en;      // issue a partial product
        mul_op_t mul_op;
        logic    sqrt_en;     // one square root iteration
        logic    fin1;        // add drift
        logic    fin2;        // add diffusion, clamp, update population
        logic    load_out;    // move result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/emps_regs.sv -----
// ============================================================================
// emps_regs: configuration register file
// APB-style slave holding the seven step parameters; it never inserts wait states.
// ============================================================================
module emps_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [emps_pkg::ADDR_W-1:0]   paddr,
    input  logic [emps_pkg::DATA_W-1:0]   pwdata,
    output logic [emps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output emps_pkg::cfg_t                cfg
);
    import emps_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BIRTH:    cfg_reg.birth_rate    <= pwdata[RATE_W-1:0];
                REG_DEATH:    cfg_reg.death_rate    <= pwdata[RATE_W-1:0];
                REG_GAIN:     cfg_reg.feedback_gain <= pwdata[RATE_W-1:0];
                REG_SETPOINT: cfg_reg.setpoint      <= pwdata[POP_W-1:0];
                REG_STEP:     cfg_reg.step_size     <= pwdata[RATE_W-1:0];
                REG_SQRT_DT:  cfg_reg.sqrt_step     <= pwdata[RATE_W-1:0];
                REG_START:    cfg_reg.start_value   <= pwdata[POP_W-1:0];
                default: ;    // drop writes to unmapped slots
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIRTH:    prdata = DATA_W'(cfg_reg.birth_rate);
            REG_DEATH:    prdata = DATA_W'(cfg_reg.death_rate);
            REG_GAIN:     prdata = DATA_W'(cfg_reg.feedback_gain);
            REG_SETPOINT: prdata = DATA_W'(cfg_reg.setpoint);
            REG_STEP:     prdata = DATA_W'(cfg_reg.step_size);
            REG_SQRT_DT:  prdata = DATA_W'(cfg_reg.sqrt_step);
            REG_START:    prdata = DATA_W'(cfg_reg.start_value);
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/emps_ctrl.sv -----
// ============================================================================
// emps_ctrl: step sequencer
// One-hot state machine that walks the datapath through one step and
// schedules the drift partial products under the square root iterations.
// ============================================================================
module emps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_restart,
    input  emps_pkg::dp_stat_t  stat,
    output emps_pkg::dp_cmd_t   cmd
);
    import emps_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    // drift multiplies ride along with the square root iterations
    localparam logic [CNT_W-1:0] SLOT_DR1_LO = CNT_W'(0);
    localparam logic [CNT_W-1:0] SLOT_DR1_HI = CNT_W'(1);
    localparam logic [CNT_W-1:0] SLOT_DR2_LO = CNT_W'(3);
    localparam logic [CNT_W-1:0] SLOT_DR2_HI = CNT_W'(4);
    localparam logic [CNT_W-1:0] SLOT_LAST   = CNT_W'(SQRT_STEPS - 1);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DIFF   = 20'h00002,
        ST_FB_LO  = 20'h00004,
        ST_FB_HI  = 20'h00008,
        ST_FB_WB  = 20'h00010,
        ST_BEFF   = 20'h00020,
        ST_RATE   = 20'h00040,
        ST_VAR_LL = 20'h00080,
        ST_VAR_HL = 20'h00100,
        ST_VAR_LH = 20'h00200,
        ST_VAR_HH = 20'h00400,
        ST_VAR_WB = 20'h00800,
        ST_SQRT   = 20'h01000,
        ST_DF1    = 20'h02000,
        ST_DF1_WB = 20'h04000,
        ST_DF2_LO = 20'h08000,
        ST_DF2_HI = 20'h10000,
        ST_DF2_WB = 20'h20000,
        ST_FIN    = 20'h40000,
        ST_DONE   = 20'h80000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_restart) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_DONE;
                    end else if (stat.dead) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_FB_LO;
            end
            ST_FB_LO: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_FB_LO;
                state_next = ST_FB_HI;
            end
            ST_FB_HI: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_FB_HI;
                state_next = ST_FB_WB;
            end
            ST_FB_WB:  state_next = ST_BEFF;
            ST_BEFF: begin
                cmd.beff   = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE: begin
                cmd.rate   = 1'b1;
                state_next = ST_VAR_LL;
            end
            ST_VAR_LL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_VAR_LL;
                state_next = ST_VAR_HL;
            end
            ST_VAR_HL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_VAR_HL;
                state_next = ST_VAR_LH;
            end
            ST_VAR_LH: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_VAR_LH;
                state_next = ST_VAR_HH;
            end
            ST_VAR_HH: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_VAR_HH;
                state_next = ST_VAR_WB;
            end
            ST_VAR_WB: begin
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_en = 1'b1;
                case (cnt_reg)
                    SLOT_DR1_LO: begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_DR1_LO;
                    end
                    SLOT_DR1_HI: begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_DR1_HI;
                    end
                    SLOT_DR2_LO: begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_DR2_LO;
                    end
                    SLOT_DR2_HI: begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_DR2_HI;
                    end
                    default: ;
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SLOT_LAST) begin
                    state_next = ST_DF1;
                end
            end
            ST_DF1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DF1;
                cmd.fin1   = 1'b1;
                state_next = ST_DF1_WB;
            end
            ST_DF1_WB: state_next = ST_DF2_LO;
            ST_DF2_LO: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DF2_LO;
                state_next = ST_DF2_HI;
            end
            ST_DF2_HI: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DF2_HI;
                state_next = ST_DF2_WB;
            end
            ST_DF2_WB: state_next = ST_FIN;
            ST_FIN: begin
                cmd.fin2   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the word
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while a step is in progress");

endmodule

// ----- hdl/emps_dp.sv -----
// ============================================================================
// emps_dp: step datapath
// Shared 32x32 multiplier with shift-accumulate, bit-per-cycle square root,
// rate arithmetic, population state and the output register.
// ============================================================================
module emps_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  emps_pkg::cfg_t                        cfg,
    input  emps_pkg::dp_cmd_t                     cmd,
    output emps_pkg::dp_stat_t                    stat,
    input  logic signed [emps_pkg::NOISE_W-1:0]   s_noise,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [emps_pkg::POP_W-1:0]            m_new_value,
    output logic                                  m_extinct
);
    import emps_pkg::*;

    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 81;
    localparam int FB_SHR   = 16;
    localparam int FB_W     = 56;
    localparam int DR1_SHR  = 24;
    localparam int DR1_W    = 48;
    localparam int DR_SHR   = 24;
    localparam int DR_W     = 56;
    localparam int VAR_SHR  = 8;
    localparam int VAR_W    = 64;
    localparam int DPROD_W  = 48;
    localparam int DIFF_SHR = 36;
    localparam int DIFF_W   = 44;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SUM_W    = 59;

    // population state
    logic [POP_W-1:0]        pop_reg;
    logic                    dead_reg;

    // per-item operands and intermediates
    logic                    nneg_reg;
    logic [NOISE_W-1:0]      nmag_reg, nmag_next;
    logic [NOISE_W-1:0]      noise_u;
    logic                    above_reg;
    logic [POP_W-1:0]        dmag_reg;
    logic [FB_W-1:0]         fb_reg;
    logic [RATE_W-1:0]       beff_reg, beff_next;
    logic [FB_W:0]           bsum;
    logic                    rneg_reg;
    logic [RATE_W-1:0]       rmag_reg;
    logic [RATE_W:0]         vsum_reg;
    logic [DR1_W-1:0]        drift1_reg;
    logic [DR_W-1:0]         drift_reg;
    logic [DPROD_W-1:0]      dprod_reg;
    logic [DIFF_W-1:0]       diff_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next, nx_next;
    logic signed [SUM_W-1:0] x_s, drift_s, diff_s;

    // multiplier and accumulator
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       prod_reg;
    mul_op_t                 op_reg;
    logic                    pipe_vld_reg;
    logic [ACC_W-1:0]        acc_reg, acc_next, addend;
    logic                    op_first;

    // square root
    logic [VAR_W-1:0]        rad_reg;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [REM_W+1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    take;

    // output register
    logic                    m_valid_reg;
    logic [POP_W-1:0]        m_value_reg;
    logic                    m_extinct_reg;

    assign stat.dead     = dead_reg;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_new_value   = m_value_reg;
    assign m_extinct     = m_extinct_reg;

    // ------------------------------------------------------------------
    // operand capture and scalar rate arithmetic
    // ------------------------------------------------------------------
    assign noise_u   = s_noise;
    assign nmag_next = noise_u[NOISE_W-1] ? (~noise_u + NOISE_W'(1)) : noise_u;

    assign bsum = (FB_W+1)'(cfg.birth_rate) + (FB_W+1)'(fb_reg);

    always_comb begin
        if (above_reg) begin
            beff_next = (|bsum[FB_W:RATE_W]) ? '1 : bsum[RATE_W-1:0];
        end else if (FB_W'(cfg.birth_rate) > fb_reg) begin
            beff_next = cfg.birth_rate - fb_reg[RATE_W-1:0];
        end else begin
            beff_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            nneg_reg <= noise_u[NOISE_W-1];
            nmag_reg <= nmag_next;
        end
        if (cmd.diff) begin
            above_reg <= (cfg.setpoint >= pop_reg);
            dmag_reg  <= (cfg.setpoint >= pop_reg) ? cfg.setpoint - pop_reg
                                                   : pop_reg - cfg.setpoint;
        end
        if (cmd.beff) begin
            beff_reg <= beff_next;
        end
        if (cmd.rate) begin
            rneg_reg <= (cfg.death_rate > beff_reg);
            rmag_reg <= (cfg.death_rate > beff_reg) ? cfg.death_rate - beff_reg
                                                    : beff_reg - cfg.death_rate;
            vsum_reg <= (RATE_W+1)'(beff_reg) + (RATE_W+1)'(cfg.death_rate);
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier: operand select, product register
    // ------------------------------------------------------------------
    always_comb begin
        case (cmd.mul_op)
            MUL_FB_LO: begin
                mul_a = dmag_reg[MUL_W-1:0];
                mul_b = cfg.feedback_gain;
            end
            MUL_FB_HI: begin
                mul_a = MUL_W'(dmag_reg[POP_W-1:MUL_W]);
                mul_b = cfg.feedback_gain;
            end
            MUL_DR1_LO: begin
                mul_a = pop_reg[MUL_W-1:0];
                mul_b = rmag_reg;
            end
            MUL_DR1_HI: begin
                mul_a = MUL_W'(pop_reg[POP_W-1:MUL_W]);
                mul_b = rmag_reg;
            end
            MUL_DR2_LO: begin
                mul_a = drift1_reg[MUL_W-1:0];
                mul_b = cfg.step_size;
            end
            MUL_DR2_HI: begin
                mul_a = MUL_W'(drift1_reg[DR1_W-1:MUL_W]);
                mul_b = cfg.step_size;
            end
            MUL_VAR_LL: begin
                mul_a = pop_reg[MUL_W-1:0];
                mul_b = vsum_reg[MUL_W-1:0];
            end
            MUL_VAR_HL: begin
                mul_a = MUL_W'(pop_reg[POP_W-1:MUL_W]);
                mul_b = vsum_reg[MUL_W-1:0];
            end
            MUL_VAR_LH: begin
                mul_a = pop_reg[MUL_W-1:0];
                mul_b = MUL_W'(vsum_reg[RATE_W]);
            end
            MUL_VAR_HH: begin
                mul_a = MUL_W'(pop_reg[POP_W-1:MUL_W]);
                mul_b = MUL_W'(vsum_reg[RATE_W]);
            end
            MUL_DF1: begin
                mul_a = root_reg;
                mul_b = MUL_W'(nmag_reg);
            end
            MUL_DF2_LO: begin
                mul_a = dprod_reg[MUL_W-1:0];
                mul_b = cfg.sqrt_step;
            end
            MUL_DF2_HI: begin
                mul_a = MUL_W'(dprod_reg[DPROD_W-1:MUL_W]);
                mul_b = cfg.sqrt_step;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= 1'b0;
        end else begin
            pipe_vld_reg <= cmd.mul_en;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
            op_reg   <= cmd.mul_op;
        end
    end

    // ------------------------------------------------------------------
    // shift-accumulate and write-back of finished products
    // ------------------------------------------------------------------
    always_comb begin
        case (op_reg) inside
            MUL_FB_HI, MUL_DR1_HI, MUL_DR2_HI, MUL_VAR_HL, MUL_VAR_LH, MUL_DF2_HI:
                addend = ACC_W'(prod_reg) << MUL_W;
            MUL_VAR_HH:
                addend = ACC_W'(prod_reg) << PROD_W;
            default:
                addend = ACC_W'(prod_reg);
        endcase
        case (op_reg) inside
            MUL_FB_LO, MUL_DR1_LO, MUL_DR2_LO, MUL_VAR_LL, MUL_DF1, MUL_DF2_LO:
                op_first = 1'b1;
            default:
                op_first = 1'b0;
        endcase
        acc_next = (op_first ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge aclk) begin
        if (pipe_vld_reg) begin
            acc_reg <= acc_next;
            case (op_reg)
                MUL_FB_HI:  fb_reg     <= acc_next[FB_SHR +: FB_W];
                MUL_DR1_HI: drift1_reg <= acc_next[DR1_SHR +: DR1_W];
                MUL_DR2_HI: drift_reg  <= acc_next[DR_SHR +: DR_W];
                MUL_DF1:    dprod_reg  <= acc_next[DPROD_W-1:0];
                MUL_DF2_HI: diff_reg   <= acc_next[DIFF_SHR +: DIFF_W];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // floor square root, two radicand bits per cycle
    // ------------------------------------------------------------------
    assign rem_sh    = {rem_reg, rad_reg[VAR_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_sh >= (REM_W+2)'(trial));
    assign rem_next  = take ? REM_W'(rem_sh - (REM_W+2)'(trial)) : rem_sh[REM_W-1:0];
    assign root_next = {root_reg[ROOT_W-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (pipe_vld_reg && (op_reg == MUL_VAR_HH)) begin
            // saturate the variance term to 64 bits and seed the root
            rad_reg  <= acc_next[VAR_SHR + VAR_W] ? '1 : acc_next[VAR_SHR +: VAR_W];
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_en) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // ------------------------------------------------------------------
    // population update
    // ------------------------------------------------------------------
    assign x_s     = SUM_W'(pop_reg);
    assign drift_s = SUM_W'(drift_reg);
    assign diff_s  = SUM_W'(diff_reg);
    assign sum_next = rneg_reg ? x_s - drift_s : x_s + drift_s;
    assign nx_next  = nneg_reg ? sum_reg - diff_s : sum_reg + diff_s;

    always_ff @(posedge aclk) begin
        if (cmd.fin1) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg  <= '0;
            dead_reg <= 1'b0;
        end else if (cmd.load_start) begin
            pop_reg  <= cfg.start_value;
            dead_reg <= 1'b0;
        end else if (cmd.fin2) begin
            if (nx_next[SUM_W-1] || (nx_next == '0)) begin
                pop_reg  <= '0;
                dead_reg <= 1'b1;
            end else if (|nx_next[SUM_W-2:POP_W]) begin
                pop_reg <= '1;
            end else begin
                pop_reg <= nx_next[POP_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_value_reg   <= pop_reg;
            m_extinct_reg <= dead_reg;
        end
    end

    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        dead_reg |-> (pop_reg == '0))
        else $error("extinct population holds a nonzero value");

    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= {1'b0, root_reg, 1'b0})
        else $error("square root remainder exceeds twice the partial root");

    a_out_extinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_extinct_reg) |-> (m_value_reg == '0))
        else $error("extinct result word carries a nonzero population");

endmodule

// ----- hdl/euler_maruyama_population_step.sv -----
// ============================================================================
// euler_maruyama_population_step: stochastic birth-death population step
// Top level: configuration registers, step sequencer and datapath.
// ============================================================================
// Each input word advances the population by one Euler-Maruyama step with a
// density-dependent birth rate, or reloads the start value when restart is
// set, and yields one result word. A stepping word runs a square root that
// settles one root bit per cycle, plus the partial products of one shared
// 32x32 multiplier (the drift products overlap the root). Restart words and
// words arriving after extinction skip the arithmetic. One word is in work
// at a time; a result waiting in the output register does not stop the next
// word from entering.
// Registers sit at byte address 8*i (64-bit data), in this order: birth
// rate, death rate, feedback gain, setpoint, step size, sqrt of step size,
// start value; write them only while the block is idle.
// ============================================================================
module euler_maruyama_population_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_noise,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [39:0]         m_new_value,
    output logic                m_extinct
);
    import emps_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    emps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    emps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .stat      (stat),
        .cmd       (cmd)
    );

    emps_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .s_noise     (s_noise),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_value (m_new_value),
        .m_extinct   (m_extinct)
    );

endmodule

// ----- sim/testbench.sv -----
// ============================================================================
// testbench: population step block, self-checking
// Programs the rate registers over the APB port, streams noise and restart
// words with random gaps and result back-pressure, and compares every result
// word against a fixed-point model of the Euler-Maruyama update kept here.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import emps_pkg::*;

    localparam logic [REG_IDX_W-1:0] UNUSED_REG = 3'd7;
    localparam logic [63:0] TERM_CAP  = 64'd1 << 60;
    localparam longint      POP_MAX   = 64'sh00FF_FFFF_FFFF;
    localparam logic [31:0] ONE_RATE  = 32'd1 << 24;
    localparam int          IDLE_LIMIT = 2000;

    typedef enum int {FAM_PLAIN, FAM_WIDE, FAM_EDGE} cfg_family_t;

    // ------------------------------------------------------------------------
    // expected-result store with its own copy of the population update
    // ------------------------------------------------------------------------
    class step_scoreboard;
        typedef struct {
            logic [POP_W-1:0] value;
            logic             extinct;
        } step_result_t;

        logic [RATE_W-1:0] birth, death, gain, dt, sqrt_dt;
        logic [POP_W-1:0]  setpt, start;
        logic [POP_W-1:0]  pop;
        logic              dead;
        step_result_t      pending[$];
        int                errors;

        function new();
            birth = '0; death = '0; gain = '0; dt = '0; sqrt_dt = '0;
            setpt = '0; start = '0; pop = '0; dead = 1'b0; errors = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                REG_BIRTH:    birth   = v[RATE_W-1:0];
                REG_DEATH:    death   = v[RATE_W-1:0];
                REG_GAIN:     gain    = v[RATE_W-1:0];
                REG_SETPOINT: setpt   = v[POP_W-1:0];
                REG_STEP:     dt      = v[RATE_W-1:0];
                REG_SQRT_DT:  sqrt_dt = v[RATE_W-1:0];
                REG_START:    start   = v[POP_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(a*b / 2^sh) from the full 128-bit product, limited to cap
        function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh,
                                             logic [63:0] cap);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> sh;
            if (p[127:64] != 64'd0)
                return cap;
            return (p[63:0] > cap) ? cap : p[63:0];
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] rem, root, probe;
            rem = v;
            root = '0;
            probe = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (rem >= root + probe) begin
                    rem = rem - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function void note_word(logic [NOISE_W-1:0] noise, logic restart);
            logic [63:0]  x, sp, nmag, dmag, g, fb, beff, rmag, drift;
            logic [63:0]  var_rate, sd, diffusion;
            logic         nneg, above, rneg;
            longint       nx;
            step_result_t r;
            x = {24'd0, pop};
            sp = {24'd0, setpt};
            nneg = noise[NOISE_W-1];
            nmag = nneg ? (64'h1_0000 - {48'd0, noise}) : {48'd0, noise};
            if (restart) begin
                pop = start;
                dead = 1'b0;
            end else if (!dead) begin
                above = sp >= x;
                dmag = above ? sp - x : x - sp;
                g = {32'd0, gain};
                fb = g * (dmag >> 16) + ((g * (dmag & 64'hFFFF)) >> 16);
                if (above) begin
                    beff = {32'd0, birth} + fb;
                    if (beff > 64'hFFFF_FFFF)
                        beff = 64'hFFFF_FFFF;
                end else begin
                    beff = ({32'd0, birth} > fb) ? {32'd0, birth} - fb : 64'd0;
                end
                rneg = {32'd0, death} > beff;
                rmag = rneg ? {32'd0, death} - beff : beff - {32'd0, death};
                drift = scaled_product(x, rmag, 24, '1);
                drift = scaled_product(drift, {32'd0, dt}, 24, TERM_CAP);
                var_rate = scaled_product(x, beff + {32'd0, death}, 8, '1);
                sd = floor_sqrt(var_rate);
                diffusion = scaled_product(sd * nmag, {32'd0, sqrt_dt}, 36, TERM_CAP);
                nx = longint'(x);
                nx = rneg ? nx - longint'(drift) : nx + longint'(drift);
                nx = nneg ? nx - longint'(diffusion) : nx + longint'(diffusion);
                if (nx <= 0) begin
                    pop = '0;
                    dead = 1'b1;
                end else if (nx > POP_MAX) begin
                    pop = '1;
                end else begin
                    pop = nx[POP_W-1:0];
                end
            end
            r.value = pop;
            r.extinct = dead;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 40)
                $display("mismatch: %s got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [POP_W-1:0] value, logic extinct);
            step_result_t want;
            if (pending.size() == 0) begin
                report_mismatch("result word with nothing expected", 64'(value), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
                report_mismatch("new_value", 64'(value), 64'(want.value));
            if (extinct !== want.extinct)
                report_mismatch("extinct", 64'(extinct), 64'(want.extinct));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, block and signals
    // ------------------------------------------------------------------------
    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid, s_ready, s_restart;
    logic signed [15:0]  s_noise;
    logic                m_valid, m_ready, m_extinct;
    logic [POP_W-1:0]    m_new_value;
    logic                quiet = 1'b0;
    int                  idle_cycles = 0;
    step_scoreboard      sb;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    euler_maruyama_population_step DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_noise     (s_noise),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_value (m_new_value),
        .m_extinct   (m_extinct)
    );

    // ------------------------------------------------------------------------
    // monitor and watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_new_value, m_extinct);
            if (s_valid && s_ready)
                sb.note_word(s_noise, s_restart);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(99) < 8) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << REG_LSB;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_rates(logic [31:0] b, logic [31:0] d, logic [31:0] g,
                             logic [39:0] sp, logic [31:0] st, logic [31:0] sq,
                             logic [39:0] x0);
        write_reg(REG_BIRTH, {32'd0, b});
        write_reg(REG_DEATH, {32'd0, d});
        write_reg(REG_GAIN, {32'd0, g});
        write_reg(REG_SETPOINT, {24'd0, sp});
        write_reg(REG_STEP, {32'd0, st});
        write_reg(REG_SQRT_DT, {32'd0, sq});
        write_reg(REG_START, {24'd0, x0});
    endtask

    function automatic logic [63:0] draw_reg(cfg_family_t fam, logic [REG_IDX_W-1:0] idx);
        logic [63:0] mask, v;
        mask = (idx == REG_SETPOINT || idx == REG_START) ? 64'hFF_FFFF_FFFF : 64'hFFFF_FFFF;
        v = {$urandom, $urandom} & mask;
        case (fam)
            FAM_PLAIN: begin
                case (idx)
                    REG_BIRTH, REG_DEATH: v = 64'($urandom_range(0, 3 << 24));
                    REG_GAIN:     v = 64'($urandom_range(0, 1 << 18));
                    REG_SETPOINT: v = (64'($urandom_range(10, 2000)) << 16) |
                                      64'($urandom_range(0, 65535));
                    REG_STEP:     v = 64'($urandom_range(1 << 14, 1 << 22));
                    REG_SQRT_DT:  v = 64'($urandom_range(1 << 21, 1 << 23));
                    REG_START:    v = 64'($urandom_range(1, 2000)) << 16;
                    default: ;
                endcase
            end
            FAM_EDGE: begin
                case ($urandom_range(2))
                    0: v = '0;
                    1: v = mask;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] draw_noise();
        case ($urandom_range(9))
            0, 1:    return 16'($urandom);
            2, 3, 4: return 16'($urandom_range(0, 24575)) - 16'd12288;
            default: return 16'($urandom_range(0, 8191)) - 16'd4096;
        endcase
    endfunction

    // ends at a falling edge, with valid low if a gap was taken
    task automatic next_slot();
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge aclk);
        end
    endtask

    // hold the word until accepted
    task automatic put_word(logic [15:0] n, logic r);
        s_valid <= 1'b1;
        s_noise <= n;
        s_restart <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_word(logic [15:0] n, logic r);
        next_slot();
        put_word(n, r);
    endtask

    // drop valid and wait until every result word is back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        cfg_family_t             fam;
        logic [REG_IDX_W-1:0]    idx;
        int                      n_words;
        logic                    restart;
        sb = new();
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_noise = '0;
        s_restart = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // moderate rates, noise extremes
        set_rates(ONE_RATE, ONE_RATE >> 1, 32'd16777, 40'(500) << 16, 32'd167772,
                  32'd1677722, 40'(100) << 16);
        write_reg(UNUSED_REG, {$urandom, $urandom});
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1000, 1'b1);
        send_word(draw_noise(), 1'b0);
        send_word(draw_noise(), 1'b0);
        send_word(draw_noise(), 1'b0);
        settle();

        // step from zero goes extinct, extinct holds, restart clears
        write_reg(REG_START, 64'd0);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h0000, 1'b1);
        settle();

        // everything at maximum but the death rate: saturate at the top
        set_rates('1, '1, '1, '1, '1, '1, '1);
        write_reg(REG_DEATH, 64'd0);
        send_word(16'h0000, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        settle();

        // heavy death rate crashes a healthy population
        set_rates('0, '1, '0, '0, '1, '0, 40'(1000) << 16);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'd1000, 1'b0);
        settle();

        // no rates at all: population holds
        set_rates('0, '0, '0, '0, '0, '0, 40'd1);
        send_word(16'h0000, 1'b1);
        send_word(16'h7FFF, 1'b0);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            fam = (ph % 5 == 3) ? FAM_WIDE : (ph % 5 == 4) ? FAM_EDGE : FAM_PLAIN;
            quiet = (ph == 4 || ph == 5);
            idx = REG_BIRTH;
            repeat (7) begin
                write_reg(idx, draw_reg(fam, idx));
                idx++;
            end
            n_words = $urandom_range(30, 50);
            for (int k = 0; k < n_words; k++) begin
                next_slot();
                // mostly restart-led runs; revive extinct populations quickly
                if (k == 0)
                    restart = ($urandom_range(9) != 0);
                else if (sb.dead)
                    restart = ($urandom_range(9) < 8);
                else
                    restart = ($urandom_range(99) < 3);
                put_word(draw_noise(), restart);
            end
            settle();
        end
        quiet = 1'b0;

        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
